/* rtl/idtp_pkg.sv */
// Package with the shared types, codes and tables of the timestamp text parser.
`timescale 1ns / 1ps
`default_nettype none

package idtp_pkg;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    localparam logic [5:0] IDX_SAT   = 6'd33;
    localparam logic [5:0] FIXED_LEN = 6'd19;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [5:0]         end_position;
        logic [13:0]        year;
        logic [3:0]         month;
        logic [4:0]         day;
        logic [4:0]         hour;
        logic [5:0]         minute;
        logic [5:0]         second;
        logic [19:0]        micros;
        logic signed [11:0] offset_minutes;
    } t_out_item;

    // Character classes that the parser distinguishes.
    typedef enum logic [2:0] {
        CLS_DIGIT,
        CLS_DASH,
        CLS_PLUS,
        CLS_T,
        CLS_COLON,
        CLS_DOT,
        CLS_Z,
        CLS_OTHER
    } t_cls;

    typedef struct packed {
        t_cls       cls;
        logic [3:0] digit;
        logic       last;
    } t_token;

    // Days in a month of a common year; month codes outside 1 to 12 give 31.
    function automatic logic [4:0] month_days(input logic [3:0] month);
        logic [4:0] days;
        unique case (month)
            4'd2:                      days = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   days = 5'd30;
            default:                   days = 5'd31;
        endcase
        return days;
    endfunction

endpackage

`default_nettype wire

/* rtl/idtp_front.sv */
// Front end: accepts text bytes, classifies them and queues the tokens.
`timescale 1ns / 1ps
`default_nettype none

module idtp_front
    import idtp_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_item i_item,
    input  wire logic     i_pop,
    output logic          o_tok_valid,
    output t_token        o_tok
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_token             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr;
    logic [PTR_W-1:0]   r_rd, n_rd;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               push;
    t_token             tok_in;

    always_comb begin
        tok_in.digit = i_item.text_byte[3:0];
        tok_in.last  = i_item.last_byte;
        unique case (i_item.text_byte)
            8'h30, 8'h31, 8'h32, 8'h33, 8'h34,
            8'h35, 8'h36, 8'h37, 8'h38, 8'h39: tok_in.cls = CLS_DIGIT;
            8'h2D:   tok_in.cls = CLS_DASH;
            8'h2B:   tok_in.cls = CLS_PLUS;
            8'h54:   tok_in.cls = CLS_T;
            8'h3A:   tok_in.cls = CLS_COLON;
            8'h2E:   tok_in.cls = CLS_DOT;
            8'h5A:   tok_in.cls = CLS_Z;
            default: tok_in.cls = CLS_OTHER;
        endcase
    end

    assign o_ready     = (r_cnt != CNT_W'(DEPTH));
    assign push        = i_valid && o_ready;
    assign o_tok_valid = (r_cnt != '0);
    assign o_tok       = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        unique case ({push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= tok_in;
        end
    end

endmodule

`default_nettype wire

/* rtl/idtp_back.sv */
// Back end: runs the parse state machine on queued tokens and holds the result register.
`timescale 1ns / 1ps
`default_nettype none

module idtp_back
    import idtp_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_tok_valid,
    input  wire t_token i_tok,
    output logic        o_pop,
    output logic        o_out_valid,
    input  wire logic   i_out_ready,
    output t_out_item   o_out_data
);

    typedef enum logic [9:0] {
        PH_FIXED     = 10'b00_0000_0001,
        PH_SELECT    = 10'b00_0000_0010,
        PH_FRAC      = 10'b00_0000_0100,
        PH_OFF_H1    = 10'b00_0000_1000,
        PH_OFF_H2    = 10'b00_0001_0000,
        PH_OFF_COLON = 10'b00_0010_0000,
        PH_OFF_M1    = 10'b00_0100_0000,
        PH_OFF_M2    = 10'b00_1000_0000,
        PH_DONE      = 10'b01_0000_0000,
        PH_ERROR     = 10'b10_0000_0000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [5:0]  r_idx, n_idx;
    logic [19:0] r_acc, n_acc;
    logic [2:0]  r_cnt, n_cnt;
    logic [13:0] r_year, n_year;
    logic [3:0]  r_month, n_month;
    logic [4:0]  r_day, n_day;
    logic [4:0]  r_hour, n_hour;
    logic [5:0]  r_min, n_min;
    logic [5:0]  r_sec, n_sec;
    logic [19:0] r_micros, n_micros;
    logic [6:0]  r_offh, n_offh;
    logic        r_neg, n_neg;
    logic [5:0]  r_off_start, n_off_start;
    logic [1:0]  r_err_code, n_err_code;
    logic [5:0]  r_err_idx, n_err_idx;
    logic [3:0]  r_tens, n_tens;
    logic        r_hi_div4, n_hi_div4;
    logic        r_leap, n_leap;

    logic        r_out_valid;
    t_out_item   r_out;
    t_out_item   out_next;

    logic        is_dig;
    logic [19:0] acc_mac;
    logic [6:0]  year_lo;
    logic        lit_pos;
    t_cls        lit_cls;
    logic        hit;
    logic [1:0]  f_code;
    logic [5:0]  f_pos;
    logic [4:0]  dim;
    logic [1:0]  fin_code;
    logic [5:0]  fin_pos;
    logic [11:0] off_mag;
    logic        done_text;

    // Weight of the last fraction digit in microseconds.
    function automatic logic [16:0] frac_scale(input logic [2:0] count);
        logic [16:0] s;
        unique case (count)
            3'd1:    s = 17'd100000;
            3'd2:    s = 17'd10000;
            3'd3:    s = 17'd1000;
            3'd4:    s = 17'd100;
            3'd5:    s = 17'd10;
            default: s = 17'd1;
        endcase
        return s;
    endfunction

    assign o_pop     = i_tok_valid && (!i_tok.last || !r_out_valid || i_out_ready);
    assign done_text = o_pop && i_tok.last;
    assign is_dig    = (i_tok.cls == CLS_DIGIT);
    assign acc_mac   = 20'(r_acc * 20'd10 + {16'd0, i_tok.digit});
    assign year_lo   = 7'(r_tens * 7'd10 + {3'd0, i_tok.digit});

    always_comb begin
        lit_pos = 1'b1;
        unique case (r_idx)
            6'd4, 6'd7:   lit_cls = CLS_DASH;
            6'd10:        lit_cls = CLS_T;
            6'd13, 6'd16: lit_cls = CLS_COLON;
            default: begin
                lit_cls = CLS_DIGIT;
                lit_pos = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_phase     = r_phase;
        n_acc       = r_acc;
        n_cnt       = r_cnt;
        n_year      = r_year;
        n_month     = r_month;
        n_day       = r_day;
        n_hour      = r_hour;
        n_min       = r_min;
        n_sec       = r_sec;
        n_micros    = r_micros;
        n_offh      = r_offh;
        n_neg       = r_neg;
        n_off_start = r_off_start;
        n_err_code  = r_err_code;
        n_err_idx   = r_err_idx;
        n_tens      = r_tens;
        n_hi_div4   = r_hi_div4;
        n_leap      = r_leap;
        hit         = 1'b0;
        f_code      = ST_INVALID;
        f_pos       = r_idx;
        dim         = 5'd31;

        unique case (r_phase)
            PH_FIXED: begin
                if (r_idx >= FIXED_LEN) begin
                    hit = 1'b1;
                end else if (lit_pos) begin
                    if (i_tok.cls != lit_cls) begin
                        hit = 1'b1;
                    end
                end else if (!is_dig) begin
                    hit = 1'b1;
                end else begin
                    n_acc = acc_mac;
                    unique case (r_idx)
                        6'd1: n_hi_div4 = (acc_mac[1:0] == 2'd0);
                        6'd2: n_tens = i_tok.digit;
                        6'd3: begin
                            if (acc_mac == 20'd0) begin
                                hit = 1'b1; f_code = ST_RANGE; f_pos = 6'd0;
                            end else begin
                                n_year = acc_mac[13:0];
                                n_acc  = '0;
                                // Century years are leap only when the century divides by four.
                                n_leap = (year_lo == 7'd0) ? r_hi_div4 : (year_lo[1:0] == 2'd0);
                            end
                        end
                        6'd6: begin
                            if (acc_mac == 20'd0 || acc_mac > 20'd12) begin
                                hit = 1'b1; f_code = ST_RANGE; f_pos = 6'd5;
                            end else begin
                                n_month = acc_mac[3:0];
                                n_acc   = '0;
                            end
                        end
                        6'd9: begin
                            if (acc_mac == 20'd0 || acc_mac > 20'd31) begin
                                hit = 1'b1; f_code = ST_RANGE; f_pos = 6'd8;
                            end else begin
                                n_day = acc_mac[4:0];
                                n_acc = '0;
                            end
                        end
                        6'd12: begin
                            if (acc_mac > 20'd23) begin
                                hit = 1'b1; f_code = ST_RANGE; f_pos = 6'd11;
                            end else begin
                                n_hour = acc_mac[4:0];
                                n_acc  = '0;
                            end
                        end
                        6'd15: begin
                            if (acc_mac > 20'd59) begin
                                hit = 1'b1; f_code = ST_RANGE; f_pos = 6'd14;
                            end else begin
                                n_min = acc_mac[5:0];
                                n_acc = '0;
                            end
                        end
                        6'd18: begin
                            if (acc_mac > 20'd59) begin
                                hit = 1'b1; f_code = ST_RANGE; f_pos = 6'd17;
                            end else begin
                                n_sec = acc_mac[5:0];
                                n_acc = '0;
                            end
                        end
                        default: ;
                    endcase
                end
                if (r_idx == FIXED_LEN - 6'd1) begin
                    n_phase = PH_SELECT;
                end
            end
            PH_SELECT, PH_FRAC: begin
                if (r_phase == PH_SELECT && i_tok.cls == CLS_DOT) begin
                    n_phase = PH_FRAC;
                    n_cnt   = '0;
                    n_acc   = '0;
                end else if (r_phase == PH_FRAC && is_dig) begin
                    if (r_cnt >= 3'd6) begin
                        hit = 1'b1; f_code = ST_RANGE;
                    end else begin
                        n_acc = acc_mac;
                        n_cnt = r_cnt + 3'd1;
                    end
                end else if (r_phase == PH_FRAC && r_cnt == 3'd0) begin
                    hit = 1'b1;
                end else begin
                    if (r_phase == PH_FRAC) begin
                        n_micros = 20'(r_acc * frac_scale(r_cnt));
                    end
                    // The offset designator follows the seconds or the fraction.
                    unique case (i_tok.cls)
                        CLS_Z: begin
                            n_offh  = '0;
                            n_neg   = 1'b0;
                            n_acc   = '0;
                            n_phase = PH_DONE;
                        end
                        CLS_PLUS, CLS_DASH: begin
                            n_neg       = (i_tok.cls == CLS_DASH);
                            n_off_start = r_idx;
                            n_acc       = '0;
                            n_phase     = PH_OFF_H1;
                        end
                        default: hit = 1'b1;
                    endcase
                end
            end
            PH_OFF_H1, PH_OFF_H2, PH_OFF_M1, PH_OFF_M2: begin
                if (!is_dig) begin
                    hit = 1'b1;
                end else begin
                    n_acc = acc_mac;
                    unique case (r_phase)
                        PH_OFF_H1: n_phase = PH_OFF_H2;
                        PH_OFF_H2: begin
                            n_offh  = acc_mac[6:0];
                            n_acc   = '0;
                            n_phase = PH_OFF_COLON;
                        end
                        PH_OFF_M1: n_phase = PH_OFF_M2;
                        default: begin
                            if (r_offh > 7'd23 || acc_mac > 20'd59) begin
                                hit = 1'b1; f_code = ST_RANGE; f_pos = r_off_start;
                            end else begin
                                n_phase = PH_DONE;
                            end
                        end
                    endcase
                end
            end
            PH_OFF_COLON: begin
                if (i_tok.cls != CLS_COLON) begin
                    hit = 1'b1;
                end else begin
                    n_phase = PH_OFF_M1;
                end
            end
            PH_DONE: begin
                hit = 1'b1;
            end
            default: ;
        endcase

        n_idx = (r_idx < IDX_SAT) ? r_idx + 6'd1 : r_idx;

        // End-of-text checks run only while no error has been seen.
        if (i_tok.last && !hit && r_err_code == ST_OK) begin
            dim = (r_month == 4'd2 && r_leap) ? 5'd29 : month_days(r_month);
            if (n_phase != PH_DONE) begin
                hit = 1'b1; f_code = ST_INVALID; f_pos = n_idx;
            end else if (r_day > dim) begin
                hit = 1'b1; f_code = ST_RANGE; f_pos = 6'd8;
            end
        end

        if (hit) begin
            n_phase    = PH_ERROR;
            n_err_code = f_code;
            n_err_idx  = f_pos;
        end
    end

    always_comb begin
        fin_code = n_err_code;
        fin_pos  = n_err_idx;
        off_mag  = 12'(n_offh * 12'd60 + n_acc[11:0]);
        out_next = '0;
        out_next.status = fin_code;
        if (fin_code == ST_OK) begin
            out_next.end_position   = n_idx;
            out_next.year           = n_year;
            out_next.month          = n_month;
            out_next.day            = n_day;
            out_next.hour           = n_hour;
            out_next.minute         = n_min;
            out_next.second         = n_sec;
            out_next.micros         = n_micros;
            out_next.offset_minutes = n_neg ? -off_mag : off_mag;
        end else begin
            out_next.end_position = fin_pos;
        end
    end

    // Every text starts from the same cleared state, after reset and after its last byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || done_text) begin
            r_phase     <= PH_FIXED;
            r_idx       <= '0;
            r_acc       <= '0;
            r_cnt       <= '0;
            r_year      <= '0;
            r_month     <= '0;
            r_day       <= '0;
            r_hour      <= '0;
            r_min       <= '0;
            r_sec       <= '0;
            r_micros    <= '0;
            r_offh      <= '0;
            r_neg       <= 1'b0;
            r_off_start <= '0;
            r_err_code  <= ST_OK;
            r_err_idx   <= '0;
            r_tens      <= '0;
            r_hi_div4   <= 1'b0;
            r_leap      <= 1'b0;
        end else if (o_pop) begin
            r_phase     <= n_phase;
            r_idx       <= n_idx;
            r_acc       <= n_acc;
            r_cnt       <= n_cnt;
            r_year      <= n_year;
            r_month     <= n_month;
            r_day       <= n_day;
            r_hour      <= n_hour;
            r_min       <= n_min;
            r_sec       <= n_sec;
            r_micros    <= n_micros;
            r_offh      <= n_offh;
            r_neg       <= n_neg;
            r_off_start <= n_off_start;
            r_err_code  <= n_err_code;
            r_err_idx   <= n_err_idx;
            r_tens      <= n_tens;
            r_hi_div4   <= n_hi_div4;
            r_leap      <= n_leap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done_text) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done_text) begin
            r_out <= out_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

/* rtl/iso_datetime_text_parser.sv */
// Top level of the strict ISO 8601 date-time text parser.
// Usage:
//   The input channel carries one text byte per transfer, with last_byte set on
//   the final byte of a timestamp. Texts follow each other without gaps.
//   The output channel carries one result per text, sent after its last byte:
//   status, end or error position, and the parsed fields (zero unless ok).
// Timing:
//   One byte is taken per cycle while the token queue has room. Each byte is
//   queued at its transfer and parsed from the head of the queue; the result
//   register is loaded when the last byte is parsed. The per-byte phase update
//   of the parse state machine sets this rate.
// Stalls:
//   When the receiver holds off a result, the parser keeps the next last-byte
//   token at the head of the queue; other bytes keep flowing until the queue of
//   FIFO_DEPTH entries fills, then o_in_ready drops.
// Reset:
//   Synchronous reset empties the queue, clears the result valid flag and puts
//   the parser at the first year digit. The parser also returns there after
//   every last byte.
`timescale 1ns / 1ps
`default_nettype none

module iso_datetime_text_parser
    import idtp_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_item i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_item     o_out_data
);

    logic   tok_valid;
    t_token tok;
    logic   pop;

    idtp_front #(
        .DEPTH (FIFO_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_item      (i_in_data),
        .i_pop       (pop),
        .o_tok_valid (tok_valid),
        .o_tok       (tok)
    );

    idtp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (tok_valid),
        .i_tok       (tok),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
